// File: rtl/iopj_pkg.sv
// shared types, constants and helpers for the interval overlap pair join
package iopj_pkg;

  localparam int GroupDepthDef = 64;
  localparam int NumBucketsDef = 8;
  localparam int NumBounds     = 7;
  localparam int IdW           = 32;
  localparam int PosW          = 16;
  localparam int SizeW         = 16;
  localparam int WeightW       = 32;
  localparam int BucketW       = 3;
  localparam int CfgIdxW       = 3;
  localparam int CfgDataW      = 32;
  localparam int InDataW       = 112;
  localparam int OutDataW      = 104;

  typedef struct packed {
    logic [SizeW-1:0] size;
    logic [IdW-1:0]   id;
    logic [PosW-1:0]  end_p;
    logic [PosW-1:0]  start_p;
  } rec_t;

  // probe record travelling down the chain
  typedef struct packed {
    logic            vld;
    logic            lst;
    rec_t            rec;
  } probe_t;

  // match report from one cell
  typedef struct packed {
    logic             hit;
    logic             lst;
    logic [IdW-1:0]   lo_id;
    logic [IdW-1:0]   hi_id;
    logic [SizeW-1:0] min_size;
  } match_t;

  function automatic logic intervals_match(rec_t a, rec_t b);
    logic [PosW-1:0] hi_e, lo_s, mx_e, mn_s;
    logic [PosW:0]   inter, uni, diff;
    logic [PosW+3:0] five;
    begin
      hi_e  = (a.end_p < b.end_p) ? a.end_p : b.end_p;
      lo_s  = (a.start_p > b.start_p) ? a.start_p : b.start_p;
      mx_e  = (a.end_p > b.end_p) ? a.end_p : b.end_p;
      mn_s  = (a.start_p < b.start_p) ? a.start_p : b.start_p;
      inter = (hi_e > lo_s) ? ({1'b0, hi_e} - {1'b0, lo_s}) : '0;
      if (mx_e <= mn_s) begin
        intervals_match = 1'b0;
      end else begin
        uni  = {1'b0, mx_e} - {1'b0, mn_s};
        diff = uni - inter;
        five = {diff, 2'b00} + {3'b000, diff};
        intervals_match = five < {3'b000, uni};
      end
    end
  endfunction

endpackage

// File: rtl/interval_overlap_pair_join_top.sv
// top level of the interval overlap pair join: control, cell chain, result path
//
// channel  dir  beat contents (tdata low bit up)
// in_      in   req_type, sequence_id, start_pos, end_pos, query_id, query_size
// out_     out  low_query_id, high_query_id, pair_weight, bucket; tlast=last,
//               tuser=group_overflow
// cfg_     in   bucket_bound_0..6 by index
//
// a record walks the chain of GROUP_DEPTH cells, one cell a cycle while no match
// pauses it; the input is ready again only once the scan ends and the state is idle
// each match pauses the chain for the serial divide, the send and any output stalls
// synchronous active-low reset clears groups, subject and overflow flag
// output stalls hold the result path and so the chain; one record at a time
module interval_overlap_pair_join_top #(
  parameter int GROUP_DEPTH = iopj_pkg::GroupDepthDef,
  parameter int NUM_BUCKETS = iopj_pkg::NumBucketsDef
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // sequence_id, start_pos, end_pos, query_id, query_size
  input  logic [iopj_pkg::InDataW-1:0]    in_tdata,
  // req_type
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // low_query_id, high_query_id, pair_weight, bucket, zero fill
  output logic [iopj_pkg::OutDataW-1:0]   out_tdata,
  output logic                            out_tlast,
  // group_overflow
  output logic                            out_tuser,
  input  logic                            cfg_we,
  input  logic [iopj_pkg::CfgIdxW-1:0]    cfg_addr,
  input  logic [iopj_pkg::CfgDataW-1:0]   cfg_wdata
);
  import iopj_pkg::*;

  localparam int CntW = $clog2(GROUP_DEPTH + 1);
  localparam int PosIdxW = $clog2(GROUP_DEPTH + 1);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DIV, S_OUT, S_SEND} state_t;

  state_t                 state_r;
  logic [CfgDataW-1:0]    bound_r [NumBounds];
  logic [IdW-1:0]         subj_r;
  logic                   subj_v_r;
  logic [CntW-1:0]        cnt_a_r, cnt_b_r;
  logic                   ovf_r;
  logic                   src_r;
  logic [PosIdxW-1:0]     step_r;
  logic                   seen_r;

  logic                   acc;
  logic                   clr;
  logic                   src_in;
  rec_t                   rec_in;
  logic [CntW-1:0]        own_cnt;
  logic                   store;

  probe_t                 entry_r;
  probe_t                 probe [GROUP_DEPTH+1];
  match_t                 match [GROUP_DEPTH];
  match_t                 hold [GROUP_DEPTH];
  logic                   adv;
  logic                   hit_cur;

  match_t                 cur_r;
  logic                   div_start, div_busy, div_done;
  logic [WeightW-1:0]     quot;
  logic [WeightW-1:0]     wt_r;
  logic [BucketW-1:0]     bkt;
  logic                   pend_r;
  logic [GROUP_DEPTH-1:0] hitv;

  // the chain advances one cell per cycle while scanning; a hit pauses it
  assign acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign src_in = in_tuser;
  assign rec_in.start_p = in_tdata[IdW +: PosW];
  assign rec_in.end_p   = in_tdata[IdW+PosW +: PosW];
  assign rec_in.id      = in_tdata[IdW+2*PosW +: IdW];
  assign rec_in.size    = in_tdata[2*IdW+2*PosW +: SizeW];
  assign clr     = acc && (!subj_v_r || in_tdata[IdW-1:0] != subj_r);
  assign own_cnt = clr ? '0 : (src_in ? cnt_b_r : cnt_a_r);
  assign store   = acc && (own_cnt < CntW'(GROUP_DEPTH));

  // probe enters only at cell zero; it is held in a register and stepped
  assign probe[0] = entry_r;

  genvar g;
  generate
    for (g = 0; g < GROUP_DEPTH; g++) begin : g_cell
      iopj_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .clr       (clr),
        .en        (adv),
        .wr_a      (store && !src_in && own_cnt == CntW'(g)),
        .wr_b      (store &&  src_in && own_cnt == CntW'(g)),
        .wr_rec    (rec_in),
        .probe_i   (probe[g]),
        .probe_src (src_r),
        .probe_o   (probe[g+1]),
        .match_o   (match[g])
      );
      assign hold[g] = match[g];
      assign hitv[g] = match[g].hit && (step_r == PosIdxW'(g + 1));
    end
  endgenerate

  // scan: step_r counts which cell's result is current
  assign hit_cur = |hitv;
  assign adv = (state_r == S_SCAN) && (step_r != PosIdxW'(GROUP_DEPTH)) &&
               !(hit_cur && !seen_r);

  iopj_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .divisor (cur_r.min_size),
    .busy    (div_busy),
    .done    (div_done),
    .quot    (quot)
  );

  always_comb begin
    bkt = BucketW'(NUM_BUCKETS - 1);
    for (int k = NumBounds - 1; k >= 0; k--) begin
      if (k < NUM_BUCKETS - 1 && cur_r.lo_id < bound_r[k]) bkt = BucketW'(k);
    end
  end

  assign div_start = (state_r == S_DIV) && !pend_r && !div_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      subj_r   <= '0;
      subj_v_r <= 1'b0;
      cnt_a_r  <= '0;
      cnt_b_r  <= '0;
      ovf_r    <= 1'b0;
      step_r   <= '0;
      seen_r   <= 1'b0;
      pend_r   <= 1'b0;
      entry_r.vld <= 1'b0;
      out_tvalid  <= 1'b0;
      for (int k = 0; k < NumBounds; k++) bound_r[k] <= '0;
    end else begin
      if (cfg_we && cfg_addr < CfgIdxW'(NumBounds)) bound_r[cfg_addr] <= cfg_wdata;
      entry_r.vld <= acc;
      unique case (state_r)
        S_IDLE: begin
          if (acc) begin
            subj_r   <= in_tdata[IdW-1:0];
            subj_v_r <= 1'b1;
            if (clr) begin
              cnt_a_r <= '0;
              cnt_b_r <= '0;
            end
            if (store) begin
              if (src_in) cnt_b_r <= own_cnt + CntW'(1);
              else        cnt_a_r <= own_cnt + CntW'(1);
            end else begin
              ovf_r <= 1'b1;
            end
            src_r       <= src_in;
            entry_r.lst <= 1'b0;
            entry_r.rec <= rec_in;
            step_r      <= '0;
            seen_r      <= 1'b0;
            state_r     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit_cur && !seen_r) begin
            if (pend_r) begin
              // send the previous match first, this one waits in its cell
              cur_r.lst <= 1'b0;
              state_r   <= S_SEND;
            end else begin
              for (int k = 0; k < GROUP_DEPTH; k++) begin
                if (step_r == PosIdxW'(k + 1)) cur_r <= hold[k];
              end
              seen_r  <= 1'b1;
              state_r <= S_DIV;
            end
          end else if (step_r == PosIdxW'(GROUP_DEPTH)) begin
            if (pend_r) begin
              cur_r.lst <= 1'b1;
              state_r   <= S_SEND;
            end else begin
              state_r <= S_IDLE;
            end
          end else begin
            step_r <= step_r + PosIdxW'(1);
            seen_r <= 1'b0;
          end
        end
        S_DIV: begin
          if (!pend_r) begin
            pend_r <= 1'b1;
          end else if (div_done) begin
            wt_r    <= quot;
            state_r <= S_SCAN;
          end
        end
        S_SEND: begin
          out_tvalid <= 1'b1;
          out_tdata  <= {5'b00000, bkt, wt_r, cur_r.hi_id, cur_r.lo_id};
          out_tlast  <= cur_r.lst;
          out_tuser  <= ovf_r;
          state_r    <= S_OUT;
        end
        S_OUT: begin
          if (out_tready) begin
            out_tvalid <= 1'b0;
            pend_r     <= 1'b0;
            if (out_tlast) begin
              state_r <= S_IDLE;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/iopj_cell.sv
// one group slot: stores a record and tests the passing probe against it
module iopj_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clr,
  input  logic              en,
  input  logic              wr_a,
  input  logic              wr_b,
  input  iopj_pkg::rec_t    wr_rec,
  input  iopj_pkg::probe_t  probe_i,
  input  logic              probe_src,
  output iopj_pkg::probe_t  probe_o,
  output iopj_pkg::match_t  match_o
);
  import iopj_pkg::*;

  rec_t   a_r, b_r;
  logic   a_v_r, b_v_r;
  probe_t probe_r;
  match_t match_r;
  rec_t   oth;
  logic   oth_v;
  match_t match_nxt;

  always_comb begin
    oth   = probe_src ? a_r : b_r;
    oth_v = probe_src ? a_v_r : b_v_r;
    match_nxt.hit = probe_i.vld && oth_v && intervals_match(probe_i.rec, oth);
    match_nxt.lst = probe_i.lst;
    match_nxt.lo_id = (probe_i.rec.id < oth.id) ? probe_i.rec.id : oth.id;
    match_nxt.hi_id = (probe_i.rec.id < oth.id) ? oth.id : probe_i.rec.id;
    match_nxt.min_size = (probe_i.rec.size < oth.size) ? probe_i.rec.size : oth.size;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      probe_r.vld <= 1'b0;
      match_r.hit <= 1'b0;
    end else begin
      if (clr) begin
        a_v_r <= 1'b0;
        b_v_r <= 1'b0;
      end
      if (wr_a) a_v_r <= 1'b1;
      if (wr_b) b_v_r <= 1'b1;
      if (en) begin
        probe_r.vld <= probe_i.vld;
        match_r.hit <= match_nxt.hit;
      end
    end
    if (wr_a) a_r <= wr_rec;
    if (wr_b) b_r <= wr_rec;
    if (en) begin
      probe_r.lst <= probe_i.lst;
      probe_r.rec <= probe_i.rec;
      match_r.lst <= match_nxt.lst;
      match_r.lo_id <= match_nxt.lo_id;
      match_r.hi_id <= match_nxt.hi_id;
      match_r.min_size <= match_nxt.min_size;
    end
  end

  assign probe_o = probe_r;
  assign match_o = match_r;
endmodule

// File: rtl/iopj_div.sv
// serial restoring divider: 2^31 / m, one quotient bit a cycle
module iopj_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [iopj_pkg::SizeW-1:0]     divisor,
  output logic                           busy,
  output logic                           done,
  output logic [iopj_pkg::WeightW-1:0]   quot
);
  import iopj_pkg::*;

  logic [5:0]         cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [SizeW:0]     rem_r, rem_nxt;
  logic [WeightW-1:0] q_r, q_nxt;
  logic [SizeW-1:0]   d_r, d_nxt;
  logic [SizeW:0]     sh;

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    d_nxt    = d_r;
    sh       = {rem_r[SizeW-1:0], (cnt_r == 6'd31)};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd31;
      rem_nxt  = '0;
      d_nxt    = divisor;
      q_nxt    = '0;
      if (divisor == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        q_nxt    = 32'h8000_0000;
      end
    end else if (busy_r) begin
      if (sh >= {1'b0, d_r}) begin
        rem_nxt = sh - {1'b0, d_r};
        q_nxt   = {q_r[WeightW-2:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt   = {q_r[WeightW-2:0], 1'b0};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    d_r   <= d_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = q_r;
endmodule
